FILE: rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

    // Format selector carried on the input tuser
    localparam logic ACT_DEC = 1'b0;
    localparam logic ACT_HEX = 1'b1;

    // ASCII codes used in the text
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [3:0] DEC_BASE = 4'd10;

    // Map one digit value to its lower-case character
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        if (d < DEC_BASE)
        begin
            return CH_ZERO + {3'd0, d};
        end
        return CH_A + {3'd0, d} - {3'd0, DEC_BASE};
    endfunction

endpackage

FILE: rtl/core/itoa_mag.sv
`timescale 1ns / 1ps

module itoa_mag
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            in_value,
    input  logic                   in_action,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] out_mag,
    output logic                   out_neg,
    output logic                   out_hex
);

    logic [63:0]            wide;
    logic [VALUE_WIDTH-1:0] val;
    logic                   neg;
    logic                   vld_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic                   hex_reg;

    // Keep the low VALUE_WIDTH bits and take the unsigned magnitude
    assign wide     = {32'd0, in_value};
    assign val      = wide[VALUE_WIDTH-1:0];
    assign neg      = (in_action == ACT_DEC) && val[VALUE_WIDTH-1];
    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    // Hold the request payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_reg <= neg ? (~val + 1'b1) : val;
            neg_reg <= neg;
            hex_reg <= (in_action == ACT_HEX);
        end
    end

    assign out_valid = vld_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_hex   = hex_reg;

endmodule

FILE: rtl/core/itoa_bcd.sv
`timescale 1ns / 1ps

module itoa_bcd
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_mag,
    input  logic                   in_neg,
    input  logic                   in_hex,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [4*((VALUE_WIDTH*30103+99999)/100000)-1:0] out_bcd,
    output logic [8*((VALUE_WIDTH+7)/8)-1:0] out_raw,
    output logic                   out_neg,
    output logic                   out_hex
);

    localparam int NDIG = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int NST  = (VALUE_WIDTH + 7) / 8;
    localparam int PW   = NST * 8;
    localparam int AW   = 4 * NDIG + PW;

    logic [NST:0]    vld_w;
    logic [NST:0]    rdy_w;
    logic [AW-1:0]   acc_w [NST+1];
    logic [PW-1:0]   raw_w [NST+1];
    logic [NST:0]    neg_w;
    logic [NST:0]    hex_w;

    // Eight shift-and-adjust steps of the double-dabble conversion
    function automatic logic [AW-1:0] dabble8(input logic [AW-1:0] acc);
        logic [AW-1:0] a;
        a = acc;
        for (int b = 0; b < 8; b++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (a[PW+4*d +: 4] >= 4'd5)
                begin
                    a[PW+4*d +: 4] = a[PW+4*d +: 4] + 4'd3;
                end
            end
            a = a << 1;
        end
        return a;
    endfunction

    assign vld_w[0] = in_valid;
    assign in_ready = rdy_w[0];
    assign acc_w[0] = {{(4*NDIG){1'b0}}, PW'(in_mag)};
    assign raw_w[0] = PW'(in_mag);
    assign neg_w[0] = in_neg;
    assign hex_w[0] = in_hex;
    assign rdy_w[NST] = out_ready;

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        logic          vld_reg;
        logic [AW-1:0] acc_reg;
        logic [PW-1:0] raw_reg;
        logic          neg_reg;
        logic          hex_reg;
        logic          en;

        assign en       = !vld_reg || rdy_w[k+1];
        assign rdy_w[k] = en;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[k];
            end
        end

        // Advance one byte of the binary value into the digits
        always_ff @(posedge clk)
        begin
            if (en && vld_w[k])
            begin
                acc_reg <= dabble8(acc_w[k]);
                raw_reg <= raw_w[k];
                neg_reg <= neg_w[k];
                hex_reg <= hex_w[k];
            end
        end

        assign vld_w[k+1] = vld_reg;
        assign acc_w[k+1] = acc_reg;
        assign raw_w[k+1] = raw_reg;
        assign neg_w[k+1] = neg_reg;
        assign hex_w[k+1] = hex_reg;
    end

    assign out_valid = vld_w[NST];
    assign out_bcd   = acc_w[NST][AW-1:PW];
    assign out_raw   = raw_w[NST];
    assign out_neg   = neg_w[NST];
    assign out_hex   = hex_w[NST];

endmodule

FILE: rtl/core/itoa_emit.sv
`timescale 1ns / 1ps

module itoa_emit
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [4*((VALUE_WIDTH*30103+99999)/100000)-1:0] in_bcd,
    input  logic [8*((VALUE_WIDTH+7)/8)-1:0] in_raw,
    input  logic                   in_neg,
    input  logic                   in_hex,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [6:0]             out_char,
    output logic                   out_last
);

    localparam int NDIG = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [127:0]       raw_wide;
    logic [4*NDIG-1:0]  sel_dig;
    logic [CW-1:0]      sel_cnt;

    logic               c_vld_reg;
    logic [4*NDIG-1:0]  c_dig_reg;
    logic [CW-1:0]      c_cnt_reg;
    logic [1:0]         c_pre_reg;
    logic               c_hex_reg;
    logic               c_en;

    logic               busy_reg;
    logic [4*NDIG-1:0]  dig_reg;
    logic [CW-1:0]      dig_cnt_reg;
    logic [1:0]         pre_cnt_reg;
    logic               hex_reg;
    logic               fire;
    logic               d_load;
    logic [CW-1:0]      top_idx;
    logic [3:0]         cur_dig;

    // Pick the digit set and count the significant digits
    assign raw_wide = 128'(in_raw);

    always_comb
    begin
        sel_dig = in_hex ? raw_wide[4*NDIG-1:0] : in_bcd;
        sel_cnt = CW'(1);
        for (int i = 0; i < NDIG; i++)
        begin
            if (sel_dig[4*i +: 4] != 4'd0)
            begin
                sel_cnt = CW'(i + 1);
            end
        end
    end

    assign c_en     = !c_vld_reg || d_load;
    assign in_ready = c_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (c_en)
        begin
            c_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && in_valid)
        begin
            c_dig_reg <= sel_dig;
            c_cnt_reg <= sel_cnt;
            c_pre_reg <= in_hex ? 2'd2 : {1'b0, in_neg};
            c_hex_reg <= in_hex;
        end
    end

    // Serialize one request, prefix first, then digits from the top
    assign fire   = busy_reg && out_ready;
    assign d_load = !busy_reg || (fire && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pre_cnt_reg <= 2'd0;
            dig_cnt_reg <= '0;
        end
        else if (d_load)
        begin
            busy_reg    <= c_vld_reg;
            pre_cnt_reg <= c_pre_reg;
            dig_cnt_reg <= c_cnt_reg;
        end
        else if (fire)
        begin
            if (pre_cnt_reg != 2'd0)
            begin
                pre_cnt_reg <= pre_cnt_reg - 2'd1;
            end
            else
            begin
                dig_cnt_reg <= dig_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_load && c_vld_reg)
        begin
            dig_reg <= c_dig_reg;
            hex_reg <= c_hex_reg;
        end
    end

    // Drive the current character from the held request
    assign top_idx = dig_cnt_reg - CW'(1);
    assign cur_dig = dig_reg[4*top_idx[IW-1:0] +: 4];

    always_comb
    begin
        if (pre_cnt_reg == 2'd0)
        begin
            out_char = digit_char(cur_dig);
        end
        else if (!hex_reg)
        begin
            out_char = CH_MINUS;
        end
        else if (pre_cnt_reg == 2'd2)
        begin
            out_char = CH_ZERO;
        end
        else
        begin
            out_char = CH_X;
        end
    end

    assign out_valid = busy_reg;
    assign out_last  = (pre_cnt_reg == 2'd0) && (dig_cnt_reg == CW'(1));

    a_dig_left: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pre_cnt_reg == 2'd0 |-> dig_cnt_reg != '0)
        else $error("digit count ran out before last character");

    a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> dig_cnt_reg <= CW'(NDIG))
        else $error("digit count beyond digit slots");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> c_cnt_reg != '0 && c_cnt_reg <= CW'(NDIG))
        else $error("significant digit count out of range");

    a_dec_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !hex_reg |-> pre_cnt_reg != 2'd2)
        else $error("decimal text with two prefix characters");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && out_last && !c_vld_reg |=> !busy_reg)
        else $error("serializer busy with no pending request");

endmodule

FILE: rtl/core/integer_to_ascii_digits_top.sv
`timescale 1ns / 1ps
// Path: magnitude register, double-dabble byte stages, capture register, serializer.
// Throughput: one character per cycle while m_tready is high; a request has 1 to 11
// characters at VALUE_WIDTH 32, sent one at a time on the single-character output port.
// Magnitude and double-dabble stages buffer ahead and take a request every unstalled cycle.
// Reset: rst_n is asynchronous and active low; it empties every stage and the serializer.
module integer_to_ascii_digits_top
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast
);

    localparam int NDIG = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int PW   = 8 * ((VALUE_WIDTH + 7) / 8);

    logic                   a_valid;
    logic                   a_ready;
    logic [VALUE_WIDTH-1:0] a_mag;
    logic                   a_neg;
    logic                   a_hex;
    logic                   b_valid;
    logic                   b_ready;
    logic [4*NDIG-1:0]      b_bcd;
    logic [PW-1:0]          b_raw;
    logic                   b_neg;
    logic                   b_hex;
    logic [6:0]             char_w;

    itoa_mag #(.VALUE_WIDTH(VALUE_WIDTH)) u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_action (s_tuser[0]),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_mag   (a_mag),
        .out_neg   (a_neg),
        .out_hex   (a_hex)
    );

    itoa_bcd #(.VALUE_WIDTH(VALUE_WIDTH)) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_mag    (a_mag),
        .in_neg    (a_neg),
        .in_hex    (a_hex),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_bcd   (b_bcd),
        .out_raw   (b_raw),
        .out_neg   (b_neg),
        .out_hex   (b_hex)
    );

    itoa_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_bcd    (b_bcd),
        .in_raw    (b_raw),
        .in_neg    (b_neg),
        .in_hex    (b_hex),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (char_w),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, char_w};

endmodule
